/* rtl/core/rtf_pkg.sv */
// ----------------------------------------------------------------------------
// rtf_pkg
// Shared types and constants of the resistive touch filter: register map,
// calibration reset values and the command word passed from front to back.
// ----------------------------------------------------------------------------
package rtf_pkg;

  // fixed field widths
  localparam int ADC_W      = 12;
  localparam int SUM_W      = 16;
  localparam int CNT_W      = 4;
  localparam int PT_W       = 9;
  localparam int JMP_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN = 3'd0,
    CFG_X_MAX = 3'd1,
    CFG_Y_MIN = 3'd2,
    CFG_Y_MAX = 3'd3,
    CFG_JUMP  = 3'd4
  } cfg_idx_t;

  // calibration after reset
  localparam logic [ADC_W-1:0] RST_X_MIN = 12'd315;
  localparam logic [ADC_W-1:0] RST_X_MAX = 12'd3750;
  localparam logic [ADC_W-1:0] RST_Y_MIN = 12'd600;
  localparam logic [ADC_W-1:0] RST_Y_MAX = 12'd3350;
  localparam logic [JMP_W-1:0] RST_JUMP  = 9'd40;

  typedef struct packed {
    logic [ADC_W-1:0] x_min;
    logic [ADC_W-1:0] x_max;
    logic [ADC_W-1:0] y_min;
    logic [ADC_W-1:0] y_max;
    logic [JMP_W-1:0] jump_limit;
  } cfg_t;

  // work handed from the front to the back
  typedef enum logic {
    CMD_RELEASE = 1'b0,
    CMD_FRAME   = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
  } cmd_t;

endpackage

/* rtl/core/rtf_if.sv */
// ----------------------------------------------------------------------------
// rtf_if
// Valid/ready channels of the touch filter: raw sample words in, points out.
// ----------------------------------------------------------------------------
interface rtf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      touched;
  logic [rtf_pkg::ADC_W-1:0] sample_x;
  logic [rtf_pkg::ADC_W-1:0] sample_y;

  modport source (output valid, touched, sample_x, sample_y, input ready);
  modport sink   (input valid, touched, sample_x, sample_y, output ready);
endinterface

interface rtf_out_if;
  logic                     valid;
  logic                     ready;
  logic [rtf_pkg::PT_W-1:0] point_x;
  logic [rtf_pkg::PT_W-1:0] point_y;
  logic                     pressed;

  modport source (output valid, point_x, point_y, pressed, input ready);
  modport sink   (input valid, point_x, point_y, pressed, output ready);
endinterface

/* rtl/core/rtf_front.sv */
// ----------------------------------------------------------------------------
// rtf_front
// Takes sample words, sums touched pairs and hands a frame command to the
// queue once SAMPLES pairs are in, or a release command on an untouched word.
// ----------------------------------------------------------------------------
module rtf_front #(
  parameter int SAMPLES = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  rtf_in_if.sink         in_ch,
  output logic           push_valid,
  output rtf_pkg::cmd_t  push_cmd,
  input  logic           push_ready
);
  import rtf_pkg::*;

  logic [SUM_W-1:0] sum_x_r, sum_y_r, sum_x_nxt, sum_y_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             accept, last;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  // running sums, wrapping at the sum width
  assign sum_x_nxt = sum_x_r + SUM_W'(in_ch.sample_x);
  assign sum_y_nxt = sum_y_r + SUM_W'(in_ch.sample_y);
  assign last      = ({1'b0, cnt_r} + (CNT_W+1)'(1)) >= (CNT_W+1)'(SAMPLES);

  // command towards the back
  assign push_valid     = accept && (!in_ch.touched || last);
  assign push_cmd.kind  = in_ch.touched ? CMD_FRAME : CMD_RELEASE;
  assign push_cmd.sum_x = sum_x_nxt;
  assign push_cmd.sum_y = sum_y_nxt;

  // accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      if (!in_ch.touched || last) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
        cnt_r   <= '0;
      end else begin
        sum_x_r <= sum_x_nxt;
        sum_y_r <= sum_y_nxt;
        cnt_r   <= cnt_r + CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/rtf_queue.sv */
// ----------------------------------------------------------------------------
// rtf_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module rtf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  rtf_pkg::cmd_t  push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rtf_pkg::cmd_t  head
);
  import rtf_pkg::*;

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  cmd_t            mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     fill_r;
  logic            do_push, do_pop;

  assign push_ready = fill_r != (AW+1)'(DEPTH);
  assign pop_valid  = fill_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - (AW+1)'(1);
      end
    end
  end

endmodule

/* rtl/core/rtf_div.sv */
// ----------------------------------------------------------------------------
// rtf_div
// Restoring unsigned divider, one quotient bit per cycle. Result is valid in
// the cycle done pulses; a zero divisor gives a meaningless quotient.
// ----------------------------------------------------------------------------
module rtf_div #(
  parameter int NW = 21,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CW = $clog2(NW+1);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r, den_r;
  logic [NW-1:0] quo_r;
  logic [DW:0]   shifted, trial;
  logic          fits;

  // one trial subtraction
  assign shifted = {rem_r, quo_r[NW-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  assign done = done_r;
  assign quot = quo_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DW-1:0] : shifted[DW-1:0];
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

endmodule

/* rtl/core/rtf_back.sv */
// ----------------------------------------------------------------------------
// rtf_back
// Executes queued commands: for a frame, averages the sums by reciprocal
// multiplication, maps them onto the screen through the bit-serial divider
// and applies the jump filter; for a release, takes the last good point.
// Either way it loads the result word into the output register.
module rtf_back #(
  parameter int SCREEN_W = 480,
  parameter int SCREEN_H = 272,
  parameter int SAMPLES  = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rtf_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  rtf_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  rtf_out_if.source      out_ch
);
  import rtf_pkg::*;

  localparam int SMAX = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
  localparam int SCW  = $clog2(SMAX + 1);
  localparam int PW   = $clog2(SMAX);
  localparam int NW   = ADC_W + SCW;
  localparam int CW   = (PW > JMP_W) ? PW : JMP_W;
  localparam int MW   = (SCW > PT_W) ? SCW : PT_W;

  // reciprocal of SAMPLES: floor(sum / SAMPLES) == (sum * RM) >> RK for any sum
  localparam int RK   = SUM_W + $clog2(SAMPLES);
  localparam int RM   = ((1 << RK) + SAMPLES - 1) / SAMPLES;
  localparam int RW   = SUM_W + 1;
  localparam int APW  = SUM_W + RW;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_AVG_X  = 8'b0000_0010,
    ST_AVG_Y  = 8'b0000_0100,
    ST_MAP    = 8'b0000_1000,
    ST_LOAD   = 8'b0001_0000,
    ST_DIV    = 8'b0010_0000,
    ST_DECIDE = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

  state_t           state_r;
  logic             axis_r;
  logic [SUM_W-1:0] sum_x_r, sum_y_r;
  logic [ADC_W-1:0] avg_x_r, avg_y_r, span_r;
  logic [NW-1:0]    prod_r;
  logic             zero_r;
  logic [PW-1:0]    px_r, py_r, good_x_r, good_y_r;
  logic             was_down_r;
  logic [PT_W-1:0]  res_x_r, res_y_r;
  logic             res_p_r;
  logic             out_valid_r;
  logic [PT_W-1:0]  out_x_r, out_y_r;
  logic             out_p_r;

  logic             div_start, div_done;
  logic [NW-1:0]    div_num, div_quot;
  logic [ADC_W-1:0] div_den;

  logic [SUM_W-1:0] avg_src;
  logic [APW-1:0]   avg_prod;
  logic [ADC_W-1:0] avg_sel, min_sel, max_sel;
  logic [NW-1:0]    scr_sel, lim;
  logic [ADC_W:0]   off_s, span_s;
  logic             map_zero;
  logic [PW-1:0]    pix, dx, dy;
  logic             jump, out_free;
  logic [MW-1:0]    mir_x, mir_y, gx_w, gy_w;

  // pixel mapping divider
  rtf_div #(
    .NW (NW),
    .DW (ADC_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // average of one axis per cycle
  assign avg_src  = (state_r == ST_AVG_Y) ? sum_y_r : sum_x_r;
  assign avg_prod = APW'(avg_src) * APW'(RM);

  // axis operand selection
  assign avg_sel = axis_r ? avg_y_r : avg_x_r;
  assign min_sel = axis_r ? cfg.y_min : cfg.x_min;
  assign max_sel = axis_r ? cfg.y_max : cfg.x_max;
  assign scr_sel = axis_r ? NW'(SCREEN_H) : NW'(SCREEN_W);
  assign lim     = scr_sel - NW'(1);

  // offset and span; a negative offset or an empty span gives pixel 0
  assign off_s    = {1'b0, avg_sel} - {1'b0, min_sel};
  assign span_s   = {1'b0, max_sel} - {1'b0, min_sel};
  assign map_zero = off_s[ADC_W] || span_s[ADC_W] || (span_s == '0);

  // clamp the quotient onto the screen
  always_comb begin
    if (zero_r) begin
      pix = '0;
    end else if (div_quot > lim) begin
      pix = lim[PW-1:0];
    end else begin
      pix = div_quot[PW-1:0];
    end
  end

  // jump test against the last good point
  assign dx   = (px_r > good_x_r) ? px_r - good_x_r : good_x_r - px_r;
  assign dy   = (py_r > good_y_r) ? py_r - good_y_r : good_y_r - py_r;
  assign jump = was_down_r &&
                ((CW'(dx) > CW'(cfg.jump_limit)) || (CW'(dy) > CW'(cfg.jump_limit)));

  // mirrored press point and plain good point
  assign mir_x = MW'(SCREEN_W) - MW'(px_r);
  assign mir_y = MW'(SCREEN_H) - MW'(py_r);
  assign gx_w  = MW'(good_x_r);
  assign gy_w  = MW'(good_y_r);

  // divider requests
  assign div_start = (state_r == ST_LOAD);
  assign div_num   = prod_r;
  assign div_den   = span_r;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign out_free = !out_valid_r || out_ch.ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      axis_r     <= 1'b0;
      good_x_r   <= '0;
      good_y_r   <= '0;
      was_down_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_cmd.kind == CMD_FRAME) begin
              sum_x_r <= q_cmd.sum_x;
              sum_y_r <= q_cmd.sum_y;
              state_r <= ST_AVG_X;
            end else begin
              res_x_r    <= gx_w[PT_W-1:0];
              res_y_r    <= gy_w[PT_W-1:0];
              res_p_r    <= 1'b0;
              good_x_r   <= '0;
              good_y_r   <= '0;
              was_down_r <= 1'b0;
              state_r    <= ST_EMIT;
            end
          end
        end
        ST_AVG_X: begin
          avg_x_r <= avg_prod[RK +: ADC_W];
          state_r <= ST_AVG_Y;
        end
        ST_AVG_Y: begin
          avg_y_r <= avg_prod[RK +: ADC_W];
          axis_r  <= 1'b0;
          state_r <= ST_MAP;
        end
        ST_MAP: begin
          prod_r  <= NW'(off_s[ADC_W-1:0]) * scr_sel;
          span_r  <= span_s[ADC_W-1:0];
          zero_r  <= map_zero;
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            if (axis_r) begin
              py_r    <= pix;
              state_r <= ST_DECIDE;
            end else begin
              px_r    <= pix;
              axis_r  <= 1'b1;
              state_r <= ST_MAP;
            end
          end
        end
        ST_DECIDE: begin
          if (jump) begin
            res_x_r <= gx_w[PT_W-1:0];
            res_y_r <= gy_w[PT_W-1:0];
            res_p_r <= 1'b0;
          end else begin
            good_x_r   <= px_r;
            good_y_r   <= py_r;
            was_down_r <= 1'b1;
            res_x_r    <= mir_x[PT_W-1:0];
            res_y_r    <= mir_y[PT_W-1:0];
            res_p_r    <= 1'b1;
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_free) begin
      out_x_r <= res_x_r;
      out_y_r <= res_y_r;
      out_p_r <= res_p_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.point_x = out_x_r;
  assign out_ch.point_y = out_y_r;
  assign out_ch.pressed = out_p_r;

endmodule

/* rtl/core/resistive_touch_filter_unit.sv */
// ----------------------------------------------------------------------------
// resistive_touch_filter_unit
// Calibrated, jump-filtered touch point from raw resistive panel samples.
// ----------------------------------------------------------------------------
// A sample word is taken whenever the two-entry command queue has room;
// words that only add to the running sums give no result. A word that
// completes a frame, or an untouched word, queues a command for the back
// end. A release goes from the queue through the result register into the
// output register. A frame is averaged, each axis is mapped onto the screen
// by the bit-serial divider, which does the two pixel mappings in turn and
// is NW = 12 + clog2(max(SCREEN_W, SCREEN_H) + 1) bits wide (NW = 21 at the
// default screen), and the point is jump-filtered before it reaches the
// output register. The averages come from a reciprocal multiplication, one
// axis after the other. The back end takes one command at a time. The user
// writes the calibration registers through the cfg port only while the
// block is idle; the block itself does not enforce this.
module resistive_touch_filter_unit #(
  parameter int SCREEN_W = 480,
  parameter int SCREEN_H = 272,
  parameter int SAMPLES  = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  rtf_in_if.sink                             in_ch,
  rtf_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [rtf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rtf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rtf_pkg::*;

  cfg_t cfg_r;
  logic push_valid, push_ready, q_valid, q_pop;
  cmd_t push_cmd, q_head;

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min      <= RST_X_MIN;
      cfg_r.x_max      <= RST_X_MAX;
      cfg_r.y_min      <= RST_Y_MIN;
      cfg_r.y_max      <= RST_Y_MAX;
      cfg_r.jump_limit <= RST_JUMP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_MIN: cfg_r.x_min      <= cfg_data[ADC_W-1:0];
        CFG_X_MAX: cfg_r.x_max      <= cfg_data[ADC_W-1:0];
        CFG_Y_MIN: cfg_r.y_min      <= cfg_data[ADC_W-1:0];
        CFG_Y_MAX: cfg_r.y_max      <= cfg_data[ADC_W-1:0];
        CFG_JUMP:  cfg_r.jump_limit <= cfg_data[JMP_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // accumulate and classify
  rtf_front #(
    .SAMPLES (SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // command queue
  rtf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .head       (q_head)
  );

  // map, filter and report
  rtf_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .SAMPLES  (SAMPLES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_cmd   (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* rtl/core/rtf_checker.sv */
// ----------------------------------------------------------------------------
// rtf_checker
// Port-level checks on the result channel of the touch filter.
// ----------------------------------------------------------------------------
module rtf_checker #(
  parameter int SCREEN_W = 480,
  parameter int SCREEN_H = 272
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [rtf_pkg::PT_W-1:0] point_x,
  input logic [rtf_pkg::PT_W-1:0] point_y,
  input logic                     pressed
);
  import rtf_pkg::*;

  // a stalled word stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // and keeps its contents
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(point_x) && $stable(point_y) && $stable(pressed))
    else $error("result word changed while stalled");

  // nothing offered straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // reported coordinates never exceed the screen width and height
  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (point_x <= SCREEN_W) && (point_y <= SCREEN_H))
    else $error("reported point off the screen");

endmodule

bind resistive_touch_filter_unit rtf_checker #(
  .SCREEN_W (SCREEN_W),
  .SCREEN_H (SCREEN_H)
) u_rtf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .point_x   (out_ch.point_x),
  .point_y   (out_ch.point_y),
  .pressed   (out_ch.pressed)
);

/* verif/rtf_point_checker.sv */
// ----------------------------------------------------------------------------
// rtf_point_checker
// Watches the sample and point channels of the touch filter. It keeps its own
// copy of the calibration and the frame history, works out the point that each
// accepted word should give, and compares every point that leaves the block
// field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module rtf_point_checker #(
  parameter int SCREEN_W = 480,
  parameter int SCREEN_H = 272,
  parameter int SAMPLES  = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rtf_in_if                              in_ch,
  rtf_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [rtf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           drain_done,
  output int                             fail_count,
  output int                             pending_points,
  output int                             frames_taken,
  output int                             jumps_rejected,
  output int                             lift_offs
);
  timeunit 1ns;
  timeprecision 1ps;

  import rtf_pkg::*;

  typedef struct packed {
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
    logic            pressed;
  } touch_point_t;

  // shadow calibration and frame history
  cfg_t             calib;
  logic [SUM_W-1:0] acc_x;
  logic [SUM_W-1:0] acc_y;
  int               pairs_taken;
  int               good_x;
  int               good_y;
  bit               was_down;
  bit               leftovers_flushed;
  touch_point_t     owed_points[$];
  touch_point_t     want;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    fail_count++;
  endtask

  // linear map of an averaged reading onto the screen, clamped to its edges
  function automatic int map_to_pixel(input logic [SUM_W-1:0] avg,
                                      input logic [ADC_W-1:0] lo,
                                      input logic [ADC_W-1:0] hi,
                                      input int screen);
    int span;
    int pix;
    span = int'(hi) - int'(lo);
    if (span <= 0) begin
      pix = 0;
    end else begin
      pix = ((int'(avg) - int'(lo)) * screen) / span;
    end
    if (pix < 0) pix = 0;
    if (pix > screen - 1) pix = screen - 1;
    return pix;
  endfunction

  // one sample word in, at most one point owed
  task automatic predict_word(input logic touched, input logic [ADC_W-1:0] sx,
                              input logic [ADC_W-1:0] sy);
    int           px;
    int           py;
    touch_point_t pt;
    if (!touched) begin
      // lift-off: last good point, then forget the press
      pt.x       = PT_W'(good_x);
      pt.y       = PT_W'(good_y);
      pt.pressed = 1'b0;
      owed_points.push_back(pt);
      lift_offs++;
      good_x      = 0;
      good_y      = 0;
      was_down    = 1'b0;
      acc_x       = '0;
      acc_y       = '0;
      pairs_taken = 0;
    end else begin
      acc_x = acc_x + SUM_W'(sx);
      acc_y = acc_y + SUM_W'(sy);
      if (pairs_taken + 1 < SAMPLES) begin
        pairs_taken++;
      end else begin
        px = map_to_pixel(SUM_W'(acc_x / SAMPLES), calib.x_min, calib.x_max, SCREEN_W);
        py = map_to_pixel(SUM_W'(acc_y / SAMPLES), calib.y_min, calib.y_max, SCREEN_H);
        acc_x       = '0;
        acc_y       = '0;
        pairs_taken = 0;
        frames_taken++;
        if (was_down && ((px > good_x ? px - good_x : good_x - px) > int'(calib.jump_limit) ||
                         (py > good_y ? py - good_y : good_y - py) > int'(calib.jump_limit)))
        begin
          // jump too far: report release at the good point, history kept
          pt.x       = PT_W'(good_x);
          pt.y       = PT_W'(good_y);
          pt.pressed = 1'b0;
          jumps_rejected++;
        end else begin
          good_x     = px;
          good_y     = py;
          was_down   = 1'b1;
          pt.x       = PT_W'(SCREEN_W - px);
          pt.y       = PT_W'(SCREEN_H - py);
          pt.pressed = 1'b1;
        end
        owed_points.push_back(pt);
      end
    end
  endtask

  // compare outgoing words, then predict from incoming ones
  always @(posedge clk) begin
    if (!rst_n) begin
      calib       = '{x_min: RST_X_MIN, x_max: RST_X_MAX, y_min: RST_Y_MIN,
                      y_max: RST_Y_MAX, jump_limit: RST_JUMP};
      acc_x       = '0;
      acc_y       = '0;
      pairs_taken = 0;
      good_x      = 0;
      good_y      = 0;
      was_down    = 1'b0;
      owed_points.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_X_MIN: calib.x_min      = cfg_data[ADC_W-1:0];
          CFG_X_MAX: calib.x_max      = cfg_data[ADC_W-1:0];
          CFG_Y_MIN: calib.y_min      = cfg_data[ADC_W-1:0];
          CFG_Y_MAX: calib.y_max      = cfg_data[ADC_W-1:0];
          CFG_JUMP:  calib.jump_limit = cfg_data[JMP_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (owed_points.size() == 0) begin
          report_mismatch($sformatf("point (%0d,%0d) pressed=%0b with nothing owed",
                                    out_ch.point_x, out_ch.point_y, out_ch.pressed));
        end else begin
          want = owed_points.pop_front();
          if (out_ch.point_x !== want.x)
            report_mismatch($sformatf("point_x %0d, expected %0d", out_ch.point_x, want.x));
          if (out_ch.point_y !== want.y)
            report_mismatch($sformatf("point_y %0d, expected %0d", out_ch.point_y, want.y));
          if (out_ch.pressed !== want.pressed)
            report_mismatch($sformatf("pressed %0b, expected %0b", out_ch.pressed,
                                      want.pressed));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_word(in_ch.touched, in_ch.sample_x, in_ch.sample_y);
      end
      // anything still owed once the run has drained never came out
      if (drain_done && !leftovers_flushed) begin
        leftovers_flushed = 1'b1;
        if (owed_points.size() != 0)
          report_mismatch($sformatf("%0d points never came out", owed_points.size()));
      end
    end
    pending_points = owed_points.size();
  end

  initial begin
    fail_count        = 0;
    pending_points    = 0;
    frames_taken      = 0;
    jumps_rejected    = 0;
    lift_offs         = 0;
    leftovers_flushed = 1'b0;
  end

endmodule

/* verif/tb_resistive_touch_filter_unit.sv */
// ----------------------------------------------------------------------------
// tb_resistive_touch_filter_unit
// Drives raw panel sample words into the touch filter through several
// calibration settings and idling patterns: a short directed opening at the
// reset calibration, then random presses, drifts, jumps, aborted presses and
// noise. The checker beside the block predicts and compares every point.
// ----------------------------------------------------------------------------
module tb_resistive_touch_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rtf_pkg::*;

  localparam int     SCREEN_W        = 480;
  localparam int     SCREEN_H        = 272;
  localparam int     SAMPLES         = 10;
  localparam int     CLK_HALF_NS     = 6;
  localparam int     RESET_CYCLES    = 12;
  localparam int     DRAIN_CYCLES    = 150;
  localparam int     PHASES          = 6;
  localparam int     WORDS_PER_PHASE = 140;
  localparam longint TIMEOUT_NS      = 5_000_000;
  localparam int     ADC_TOP         = (1 << ADC_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  drain_done;

  int fail_count;
  int pending_points;
  int frames_taken;
  int jumps_rejected;
  int lift_offs;
  int sender_idle_pct;
  int stall_pct;
  int words_sent;

  rtf_in_if  in_ch ();
  rtf_out_if out_ch ();

  resistive_touch_filter_unit #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .SAMPLES  (SAMPLES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rtf_point_checker #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .SAMPLES  (SAMPLES)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .drain_done     (drain_done),
    .fail_count     (fail_count),
    .pending_points (pending_points),
    .frames_taken   (frames_taken),
    .jumps_rejected (jumps_rejected),
    .lift_offs      (lift_offs)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // point receiver, stalling at random
  always @(posedge clk) begin
    out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [ADC_W-1:0] clip_adc(input int v);
    if (v < 0) return '0;
    if (v > ADC_TOP) return ADC_W'(ADC_TOP);
    return ADC_W'(v);
  endfunction

  function automatic logic [ADC_W-1:0] near(input int centre, input int spread);
    return clip_adc(centre + int'($urandom_range(2 * spread)) - spread);
  endfunction

  // one sample word, with random sender gaps ahead of it
  task automatic send_word(input logic touched, input logic [ADC_W-1:0] sx,
                           input logic [ADC_W-1:0] sy);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.touched  <= touched;
    in_ch.sample_x <= sx;
    in_ch.sample_y <= sy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // a full frame of touched pairs scattered around one point
  task automatic send_frame(input int bx, input int by, input int spread);
    repeat (SAMPLES) send_word(1'b1, near(bx, spread), near(by, spread));
  endtask

  // press with drifting frames, the odd far jump, sometimes cut short
  task automatic press_sequence();
    int frames;
    int f;
    int bx;
    int by;
    frames = $urandom_range(6, 1);
    bx     = $urandom_range(ADC_TOP);
    by     = $urandom_range(ADC_TOP);
    for (f = 0; f < frames; f++) begin
      if ($urandom_range(5) == 0) begin
        bx = $urandom_range(ADC_TOP);
        by = $urandom_range(ADC_TOP);
      end else begin
        bx = clip_adc(bx + int'($urandom_range(160)) - 80);
        by = clip_adc(by + int'($urandom_range(160)) - 80);
      end
      send_frame(bx, by, $urandom_range(12));
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(SAMPLES - 1, 1)) send_word(1'b1, near(bx, 4), near(by, 4));
    end
    send_word(1'b0, ADC_W'($urandom_range(ADC_TOP)), ADC_W'($urandom_range(ADC_TOP)));
  endtask

  // frames of rail readings: all low, all high, or alternating
  task automatic rail_sequence();
    int pick;
    int i;
    pick = $urandom_range(2);
    repeat (2) begin
      for (i = 0; i < SAMPLES; i++) begin
        case (pick)
          0:       send_word(1'b1, '0, '0);
          1:       send_word(1'b1, ADC_W'(ADC_TOP), ADC_W'(ADC_TOP));
          default: send_word(1'b1, (i % 2) ? ADC_W'(ADC_TOP) : '0,
                             (i % 2) ? '0 : ADC_W'(ADC_TOP));
        endcase
      end
    end
    send_word(1'b0, '0, ADC_W'(ADC_TOP));
  endtask

  // register writes on consecutive edges, block idle
  task automatic write_calibration(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_X_MIN;
    cfg_data  <= c.x_min;
    @(posedge clk);
    cfg_index <= CFG_X_MAX;
    cfg_data  <= c.x_max;
    @(posedge clk);
    cfg_index <= CFG_Y_MIN;
    cfg_data  <= c.y_min;
    @(posedge clk);
    cfg_index <= CFG_Y_MAX;
    cfg_data  <= c.y_max;
    @(posedge clk);
    cfg_index <= CFG_JUMP;
    cfg_data  <= CFG_DATA_W'(c.jump_limit);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t calibration_for(input int phase);
    cfg_t c;
    c = '{x_min: RST_X_MIN, x_max: RST_X_MAX, y_min: RST_Y_MIN, y_max: RST_Y_MAX,
          jump_limit: RST_JUMP};
    case (phase)
      // full span on x, reversed y, nothing ever too far
      1: c = '{x_min: '0, x_max: ADC_W'(ADC_TOP), y_min: ADC_W'(ADC_TOP), y_max: '0,
               jump_limit: JMP_W'(511)};
      // empty x span, full y, no movement allowed
      2: c = '{x_min: 12'd2000, x_max: 12'd2000, y_min: '0, y_max: ADC_W'(ADC_TOP),
               jump_limit: '0};
      3: c = '{x_min: ADC_W'($urandom_range(1500)), x_max: ADC_W'($urandom_range(4095, 2500)),
               y_min: ADC_W'($urandom_range(1500)), y_max: ADC_W'($urandom_range(4095, 2500)),
               jump_limit: JMP_W'($urandom_range(120))};
      4: c = '{x_min: ADC_W'($urandom_range(ADC_TOP)), x_max: ADC_W'($urandom_range(ADC_TOP)),
               y_min: ADC_W'($urandom_range(ADC_TOP)), y_max: ADC_W'($urandom_range(ADC_TOP)),
               jump_limit: JMP_W'($urandom_range(511))};
      default: ;
    endcase
    return c;
  endfunction

  // drop valid and let the block drain before anything changes
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int phase;
    int target;
    int pick;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.touched   <= 1'b0;
    in_ch.sample_x  <= '0;
    in_ch.sample_y  <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_X_MIN;
    cfg_data        <= '0;
    drain_done      <= 1'b0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    words_sent      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
        1:       begin sender_idle_pct = 72; stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  stall_pct = 72; end
        default: begin sender_idle_pct = 9;  stall_pct = 9;  end
      endcase
      if (phase != 0) begin
        write_calibration(calibration_for(phase));
      end else begin
        // reset calibration: release from reset, clamp high, jump back to the rail
        send_word(1'b0, '0, '0);
        send_frame(ADC_TOP, ADC_TOP, 0);
        send_frame(0, 0, 0);
        send_word(1'b0, ADC_W'(ADC_TOP), ADC_W'(ADC_TOP));
      end
      target = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) begin
        pick = $urandom_range(9);
        if (pick < 7) begin
          press_sequence();
        end else if (pick < 9) begin
          repeat ($urandom_range(4, 1))
            send_word(1'($urandom_range(1)), ADC_W'($urandom_range(ADC_TOP)),
                      ADC_W'($urandom_range(ADC_TOP)));
        end else begin
          rail_sequence();
        end
      end
      settle_idle();
    end

    drain_done <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    $display("run covered %0d sample words over %0d calibration phases", words_sent, PHASES);
    $display("frames %0d, jumps rejected %0d, lift-offs %0d", frames_taken, jumps_rejected,
             lift_offs);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("watchdog expired with %0d points outstanding", pending_points);
    $display("TEST FAILED");
    $finish;
  end

endmodule
